// ----- rtl/clmd_pkg.sv -----
// Shared types and constants for the cross local maximum detector.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package clmd_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int PIXEL_BITS_DEF = 16;
	localparam int MAX_HEIGHT     = 1024;

	localparam int DIM_BITS     = 11;
	localparam int ROW_BITS     = 10;
	localparam int COL_OUT_BITS = 10;
	localparam int DIM_MIN      = 3;
	localparam int DIM_RESET    = 5;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// register indexes of the configuration port
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// one classified pixel: up to two reports, the interior one for the row above
	typedef struct packed {
		logic                    int_v;
		logic                    int_flag;
		logic                    bor_v;
		logic [ROW_BITS-1:0]     row;
		logic [COL_OUT_BITS-1:0] col;
	} job_t;

endpackage

`default_nettype wire

// ----- rtl/clmd_front.sv -----
// Front end: accepts pixels, tracks position, holds the line stores and
// classifies each pixel into a job. Depends on clmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clmd_front #(
	parameter int MAX_WIDTH  = clmd_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = clmd_pkg::PIXEL_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic                                cfg_index,
	input  wire logic [clmd_pkg::DIM_BITS-1:0]       cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [PIXEL_BITS-1:0]        pixel_value,
	input  wire logic                                q_full,
	output logic                                     push,
	output clmd_pkg::job_t                           job
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int DB = clmd_pkg::DIM_BITS;
	localparam int RW = clmd_pkg::ROW_BITS;

	// each word holds {older row, previous row} for one column
	logic [2*PIXEL_BITS-1:0] mem [MAX_WIDTH];

	logic [WW-1:0]               w_q;
	logic [DB-1:0]               h_q;
	logic [RW-1:0]               row_q;
	logic [AW-1:0]               col_q;
	logic signed [PIXEL_BITS-1:0] left_q;
	logic [2*PIXEL_BITS-1:0]     cur_q;
	logic [2*PIXEL_BITS-1:0]     nxt_q;

	logic [WW-1:0] w_new;
	logic [DB-1:0] h_new;
	logic          accept;
	logic          last_col, last_row;
	logic          int_v, bor_v, flag;
	logic signed [PIXEL_BITS-1:0] center, up, right;
	logic [AW-1:0] col_nx;
	logic [RW-1:0] row_nx;
	logic [AW:0]   col_nx_inc;
	logic [AW-1:0] rd0, rd1;
	logic          rd_en;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// clamp register writes into the meaningful range
	always_comb begin
		if (int'(cfg_data) < clmd_pkg::DIM_MIN) begin
			w_new = WW'(clmd_pkg::DIM_MIN);
		end else if (int'(cfg_data) > MAX_WIDTH) begin
			w_new = WW'(MAX_WIDTH);
		end else begin
			w_new = WW'(cfg_data);
		end
		if (int'(cfg_data) < clmd_pkg::DIM_MIN) begin
			h_new = DB'(clmd_pkg::DIM_MIN);
		end else if (int'(cfg_data) > clmd_pkg::MAX_HEIGHT) begin
			h_new = DB'(clmd_pkg::MAX_HEIGHT);
		end else begin
			h_new = cfg_data;
		end
	end

	assign center = cur_q[PIXEL_BITS-1:0];
	assign up     = cur_q[2*PIXEL_BITS-1:PIXEL_BITS];
	assign right  = nxt_q[PIXEL_BITS-1:0];

	assign last_col = (WW'(col_q) == (w_q - WW'(1)));
	assign last_row = (DB'(row_q) == (h_q - DB'(1)));
	assign int_v    = (row_q >= RW'(2)) && (col_q != '0) && !last_col;
	assign bor_v    = (row_q == '0) || last_row || (col_q == '0) || last_col;
	assign flag     = (center >= up) && (center >= pixel_value) &&
	                  (center >= left_q) && (center >= right);

	assign col_nx = last_col ? '0 : (col_q + AW'(1));
	assign row_nx = last_col ? (last_row ? '0 : (row_q + RW'(1))) : row_q;

	// prefetch the center and right words of the next position
	assign col_nx_inc = {1'b0, col_nx} + (AW+1)'(1);
	always_comb begin
		if (cfg_we) begin
			rd0 = '0;
			rd1 = AW'(1);
		end else begin
			rd0 = col_nx;
			rd1 = (col_nx_inc == (AW+1)'(MAX_WIDTH)) ? '0 : col_nx_inc[AW-1:0];
		end
	end
	assign rd_en = cfg_we || accept;

	assign push         = accept && (int_v || bor_v);
	assign job.int_v    = int_v;
	assign job.int_flag = flag;
	assign job.bor_v    = bor_v;
	assign job.row      = row_q;
	assign job.col      = clmd_pkg::COL_OUT_BITS'(col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q   <= WW'(clmd_pkg::DIM_RESET);
			h_q   <= DB'(clmd_pkg::DIM_RESET);
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				clmd_pkg::REG_FRAME_WIDTH:  w_q <= w_new;
				clmd_pkg::REG_FRAME_HEIGHT: h_q <= h_new;
				default: ;
			endcase
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			row_q <= row_nx;
			col_q <= col_nx;
		end
	end

	// write and prefetch never hit the same column in one cycle, unless a config write meets an accepted pixel
	always_ff @(posedge clk) begin
		if (accept) begin
			mem[col_q] <= {center, pixel_value};
			left_q     <= center;
		end
		if (rd_en) begin
			cur_q <= mem[rd0];
			nxt_q <= mem[rd1];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/clmd_queue.sv -----
// Short job queue between front and back end.
// Depends on clmd_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module clmd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire clmd_pkg::job_t push_job,
	output logic                full,
	input  wire logic           pop,
	output logic                head_v,
	output clmd_pkg::job_t      head_job
);

	localparam int QA = clmd_pkg::QUEUE_AW;

	clmd_pkg::job_t fifo_q [clmd_pkg::QUEUE_DEPTH];
	logic [QA-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QA:0]    count_q;

	assign full     = (count_q == (QA+1)'(clmd_pkg::QUEUE_DEPTH));
	assign head_v   = (count_q != '0);
	assign head_job = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QA'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QA'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QA+1)'(1);
				2'b01:   count_q <= count_q - (QA+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/clmd_back.sv -----
// Back end: expands each job into one or two results and holds them in the
// output register. Depends on clmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clmd_back (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               head_v,
	input  wire clmd_pkg::job_t                     head_job,
	output logic                                    pop,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [clmd_pkg::ROW_BITS-1:0]           out_row,
	output logic [clmd_pkg::COL_OUT_BITS-1:0]       out_col,
	output logic                                    is_local_max,
	output logic                                    last_of_run
);

	localparam int RW = clmd_pkg::ROW_BITS;

	logic                              out_v_q, pend_v_q;
	logic [RW-1:0]                     row_q, pend_row_q;
	logic [clmd_pkg::COL_OUT_BITS-1:0] col_q, pend_col_q;
	logic                              flag_q, last_q;
	logic                              out_free;

	assign out_free = !out_v_q || out_ready;
	assign pop      = out_free && !pend_v_q && head_v;

	assign out_valid    = out_v_q;
	assign out_row      = row_q;
	assign out_col      = col_q;
	assign is_local_max = flag_q;
	assign last_of_run  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (out_free) begin
			priority if (pend_v_q) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (head_v) begin
				out_v_q  <= 1'b1;
				pend_v_q <= head_job.int_v && head_job.bor_v;
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	// interior report first (row above), border report of the pixel after it
	always_ff @(posedge clk) begin
		if (out_free) begin
			priority if (pend_v_q) begin
				row_q  <= pend_row_q;
				col_q  <= pend_col_q;
				flag_q <= 1'b0;
				last_q <= 1'b1;
			end else if (head_v) begin
				col_q      <= head_job.col;
				pend_row_q <= head_job.row;
				pend_col_q <= head_job.col;
				if (head_job.int_v) begin
					row_q  <= head_job.row - RW'(1);
					flag_q <= head_job.int_flag;
					last_q <= !head_job.bor_v;
				end else begin
					row_q  <= head_job.row;
					flag_q <= 1'b0;
					last_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cross_local_max_detector.sv -----
// Four-neighbor local maximum detector over a raster-order pixel stream.
// Top level: front end, job queue and back end. Depends on clmd_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready, pixel_value): one signed pixel per
//    transaction, raster order; row/column counters wrap at frame end.
//  - Output channel (out_valid/out_ready): one result per transaction with
//    out_row, out_col, is_local_max and last_of_run (last result of a pixel).
//  - Config port (cfg_we, cfg_index, cfg_data): index 0 frame width, index 1
//    frame height, clamped to 3..MAX_WIDTH and 3..1024. Any write restarts
//    the frame at (0,0); line store contents are kept.
//  - Data path: a pixel's job enters the queue at its accepting edge and
//    moves into the output register once it heads the queue and the back end is free.
//  - Throughput: one pixel per cycle while the queue has room (one line store
//    write and two prefetch reads per pixel). Interior pixels of the last
//    row yield two results, so once the queue fills, result delivery paces them.
//  - Stalls: when out_ready is low the four-entry job queue fills, then
//    in_ready drops until the receiver takes results again.
//  - Reset: counters zero, both dimensions 5, queue and output empty. Line
//    stores are not cleared; they are written before any interior report.
`timescale 1ns / 1ps
`default_nettype none

module cross_local_max_detector #(
	parameter int MAX_WIDTH  = clmd_pkg::MAX_WIDTH_DEF,
	parameter int PIXEL_BITS = clmd_pkg::PIXEL_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic                               cfg_index,
	input  wire logic [clmd_pkg::DIM_BITS-1:0]      cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic signed [PIXEL_BITS-1:0]       pixel_value,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic [clmd_pkg::ROW_BITS-1:0]           out_row,
	output logic [clmd_pkg::COL_OUT_BITS-1:0]       out_col,
	output logic                                    is_local_max,
	output logic                                    last_of_run
);

	// front -> queue
	logic           push, q_full;
	clmd_pkg::job_t push_job;

	// queue -> back
	logic           pop, head_v;
	clmd_pkg::job_t head_job;

	// position tracking, line stores and classification
	clmd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_value (pixel_value),
		.q_full      (q_full),
		.push        (push),
		.job         (push_job)
	);

	// decouples pixel intake from result delivery
	clmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head_v   (head_v),
		.head_job (head_job)
	);

	// result expansion and output register
	clmd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_v       (head_v),
		.head_job     (head_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_row      (out_row),
		.out_col      (out_col),
		.is_local_max (is_local_max),
		.last_of_run  (last_of_run)
	);

endmodule

`default_nettype wire

// ----- verif/clmd_report_checker.sv -----
// Checker for the cross local maximum detector: predicts each report from the
// pixel and config transactions it sees and compares results. Uses clmd_pkg.
`timescale 1ns / 1ps

module clmd_report_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic                                  cfg_index,
	input  logic [clmd_pkg::DIM_BITS-1:0]         cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic signed [clmd_pkg::PIXEL_BITS_DEF-1:0] pixel_value,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic [clmd_pkg::ROW_BITS-1:0]         out_row,
	input  logic [clmd_pkg::COL_OUT_BITS-1:0]     out_col,
	input  logic                                  is_local_max,
	input  logic                                  last_of_run,
	output int                                    mismatch_count,
	output int                                    pending
);

	localparam int PB = clmd_pkg::PIXEL_BITS_DEF;
	localparam int RB = clmd_pkg::ROW_BITS;
	localparam int CB = clmd_pkg::COL_OUT_BITS;
	localparam int DB = clmd_pkg::DIM_BITS;
	localparam int MW = clmd_pkg::MAX_WIDTH_DEF;

	typedef logic signed [PB-1:0] pixel_t;

	typedef struct packed {
		logic [RB-1:0] row;
		logic [CB-1:0] col;
		logic          peak;
		logic          last_flag;
	} report_t;

	report_t pending_reports[$];
	report_t oldest;

	logic [DB-1:0] width_reg;
	logic [DB-1:0] height_reg;
	pixel_t        line_prev [MW];
	pixel_t        line_older[MW];
	pixel_t        left_above;
	int unsigned   row_cnt;
	int unsigned   col_cnt;

	function automatic int unsigned clamp_dim(input logic [DB-1:0] v, input int unsigned hi);
		if (v < clmd_pkg::DIM_MIN)
			return clmd_pkg::DIM_MIN;
		if (v > hi)
			return hi;
		return v;
	endfunction

	task automatic note_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Work out the reports one pixel causes and advance the frame position.
	task automatic classify_pixel(input pixel_t px);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		pixel_t      center;
		pixel_t      up;
		pixel_t      right;
		report_t     above_rep;
		report_t     here_rep;
		logic        has_above;
		logic        has_here;
		w = clamp_dim(width_reg, MW);
		h = clamp_dim(height_reg, clmd_pkg::MAX_HEIGHT);
		r = row_cnt;
		c = col_cnt;
		if (c >= w)
			c = w - 1;
		if (r >= h)
			r = h - 1;
		center    = line_prev[c];
		up        = line_older[c];
		has_above = (r >= 2) && (c >= 1) && (c + 1 < w);
		has_here  = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
		above_rep = '0;
		here_rep  = '0;
		if (has_above) begin
			right               = line_prev[c + 1];
			above_rep.row       = RB'(r - 1);
			above_rep.col       = CB'(c);
			above_rep.peak      = (center >= up) && (center >= px) &&
			                      (center >= left_above) && (center >= right);
			above_rep.last_flag = !has_here;
			pending_reports.push_back(above_rep);
		end
		if (has_here) begin
			here_rep.row       = RB'(r);
			here_rep.col       = CB'(c);
			here_rep.last_flag = 1'b1;
			pending_reports.push_back(here_rep);
		end
		left_above    = center;
		line_older[c] = center;
		line_prev[c]  = px;
		if (c + 1 >= w) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
			row_cnt = r;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg      = clmd_pkg::DIM_RESET;
			height_reg     = clmd_pkg::DIM_RESET;
			row_cnt        = 0;
			col_cnt        = 0;
			left_above     = '0;
			mismatch_count = 0;
			for (int k = 0; k < MW; k++) begin
				line_prev[k]  = '0;
				line_older[k] = '0;
			end
			pending_reports.delete();
			pending = 0;
		end else begin
			// any register write restarts the frame
			if (cfg_we) begin
				if (cfg_index == clmd_pkg::REG_FRAME_WIDTH)
					width_reg = cfg_data;
				else
					height_reg = cfg_data;
				row_cnt = 0;
				col_cnt = 0;
			end
			if (in_valid && in_ready)
				classify_pixel(pixel_value);
			if (out_valid && out_ready) begin
				if (pending_reports.size() == 0) begin
					note_mismatch($sformatf("unexpected result row %0d col %0d",
						out_row, out_col));
				end else begin
					oldest = pending_reports.pop_front();
					if (out_row !== oldest.row)
						note_mismatch($sformatf("out_row %0d, want %0d", out_row, oldest.row));
					if (out_col !== oldest.col)
						note_mismatch($sformatf("out_col %0d, want %0d", out_col, oldest.col));
					if (is_local_max !== oldest.peak)
						note_mismatch($sformatf("is_local_max %b, want %b at (%0d,%0d)",
							is_local_max, oldest.peak, oldest.row, oldest.col));
					if (last_of_run !== oldest.last_flag)
						note_mismatch($sformatf("last_of_run %b, want %b at (%0d,%0d)",
							last_of_run, oldest.last_flag, oldest.row, oldest.col));
				end
			end
			pending = pending_reports.size();
		end
	end

endmodule

// ----- verif/tb_cross_local_max_detector.sv -----
// Testbench top for the cross local maximum detector: clock, reset, pixel and
// config stimulus, receiver back-pressure and the verdict. Uses clmd_pkg and
// clmd_report_checker.
`timescale 1ns / 1ps

module tb_cross_local_max_detector;

	localparam int PB = clmd_pkg::PIXEL_BITS_DEF;
	localparam int DB = clmd_pkg::DIM_BITS;

	typedef logic signed [PB-1:0] pixel_t;

	// pixel content styles
	typedef enum int {
		PAT_FULL,   // uniform over the whole 16-bit range
		PAT_TIES,   // tiny range, lots of equal neighbors
		PAT_FLAT,   // one value for the whole phase, every interior pixel with all neighbors in the phase is a max
		PAT_RAILS   // only the extremes and the values around zero
	} pattern_e;

	logic                                  clk = 1'b0;
	logic                                  arst_n;
	logic                                  cfg_we;
	logic                                  cfg_index;
	logic [DB-1:0]                         cfg_data;
	logic                                  in_valid;
	logic                                  in_ready;
	pixel_t                                pixel_value;
	logic                                  out_valid;
	logic                                  out_ready;
	logic [clmd_pkg::ROW_BITS-1:0]         out_row;
	logic [clmd_pkg::COL_OUT_BITS-1:0]     out_col;
	logic                                  is_local_max;
	logic                                  last_of_run;

	int mismatch_count;
	int pending;

	// idle percentages of the two sides, changed between stimulus stretches
	int tx_idle_pct;
	int rx_idle_pct;

	pixel_t flat_value;

	// Hand-made 5x5 frame for the reset dimensions: extremes on the border,
	// strict maxima, maxima by ties, and non-maxima that lose by one side only.
	pixel_t demo_frame [0:24] = '{
		16'h8000, 16'h0000, 16'hFFFF, 16'h7FFF, 16'h0005,
		16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
		16'hFFFF, 16'h8000, 16'h0007, 16'h7FFF, 16'h8000,
		16'h0003, 16'h0007, 16'h0007, 16'h0007, 16'h8001,
		16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF
	};

	cross_local_max_detector u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_value  (pixel_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_row      (out_row),
		.out_col      (out_col),
		.is_local_max (is_local_max),
		.last_of_run  (last_of_run)
	);

	clmd_report_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pixel_value    (pixel_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_row        (out_row),
		.out_col        (out_col),
		.is_local_max   (is_local_max),
		.last_of_run    (last_of_run),
		.mismatch_count (mismatch_count),
		.pending        (pending)
	);

	always #1 clk = ~clk;

	// Receiver side: a fresh ready decision on every falling edge.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	function automatic pixel_t make_pixel(input pattern_e pat);
		case (pat)
			PAT_FULL:
				return pixel_t'($urandom);
			PAT_TIES:
				return pixel_t'($urandom_range(4)) - pixel_t'(2);
			PAT_FLAT:
				return flat_value;
			default:
				case ($urandom_range(3))
					0:       return 16'h8000;
					1:       return 16'h7FFF;
					2:       return 16'hFFFF;
					default: return 16'h0000;
				endcase
		endcase
	endfunction

	// One pixel transaction. Entered and left on a falling edge; valid is only
	// dropped while the sender idles, so back-to-back pixels keep it high.
	task automatic send_pixel(input pixel_t value);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		pixel_value <= value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Register write; the block has to be idle when this is called.
	task automatic write_reg(input logic idx, input logic [DB-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// Stop sending, let every expected result arrive, then keep the pipeline running
	// so that pixels without any report have settled too.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// One stretch of pixels under a setting. which[0] writes the width,
	// which[1] the height; with neither the frame just carries on.
	task automatic run_phase(input logic [DB-1:0] w_raw, input logic [DB-1:0] h_raw,
	                         input logic [1:0] which, input int count, input pattern_e pat);
		if (which[0])
			write_reg(clmd_pkg::REG_FRAME_WIDTH, w_raw);
		if (which[1])
			write_reg(clmd_pkg::REG_FRAME_HEIGHT, h_raw);
		flat_value = pixel_t'($urandom);
		for (int i = 0; i < count; i++)
			send_pixel(make_pixel(pat));
		wait_idle();
	endtask

	initial begin
		int            total;
		int            count;
		logic [DB-1:0] w_raw;
		logic [DB-1:0] h_raw;
		logic [1:0]    which;
		pattern_e      pat;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = clmd_pkg::REG_FRAME_WIDTH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		pixel_value = '0;
		out_ready   = 1'b0;
		tx_idle_pct = 16;
		rx_idle_pct = 70;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: one full 5x5 frame at the reset dimensions.
		for (int i = 0; i < 25; i++)
			send_pixel(demo_frame[i]);
		wait_idle();

		// Dimensions below the minimum act as 3; flat frame plus a wrap into
		// the next frame.
		run_phase(11'd0, 11'd1, 2'b11, 13, PAT_FLAT);
		// Exact minimum, width only rewritten, then height: restarts mid-frame.
		run_phase(11'd3, 11'd3, 2'b11, 7, PAT_RAILS);
		run_phase(11'd2, 11'd3, 2'b01, 5, PAT_TIES);
		run_phase(11'd3, 11'd4, 2'b10, 14, PAT_TIES);
		// Height above the maximum acts as 1024, narrowest width.
		run_phase(11'd2, 11'd2047, 2'b11, 12, PAT_TIES);
		// Oversized width acts as the widest frame.
		run_phase(11'd2047, 11'd0, 2'b11, 24, PAT_FULL);
		// Exact maximum width, partial frame cut off by the next write.
		run_phase(11'd1024, 11'd4, 2'b11, 16, PAT_RAILS);

		// Random settings, mostly small frames; occasionally a raw value from
		// the whole register range or no write at all.
		total = 0;
		while (total < 340) begin
			if (total < 170) begin
				tx_idle_pct = 70;
				rx_idle_pct = 16;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			w_raw = ($urandom_range(7) == 0) ? DB'($urandom_range(2047))
			                                 : DB'($urandom_range(3, 10));
			h_raw = ($urandom_range(7) == 0) ? DB'($urandom_range(2047))
			                                 : DB'($urandom_range(3, 8));
			which = ($urandom_range(7) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
			count = $urandom_range(1, 60);
			pat   = pattern_e'($urandom_range(3));
			run_phase(w_raw, h_raw, which, count, pat);
			total += count;
		end

		if (mismatch_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
